@@ sv/blsp_pkg.sv @@
// Shared types, phase codes and helpers for the binary load segment parser.
package blsp_pkg;

   localparam logic [7:0]  HEADER_BYTE   = 8'hff;
   localparam logic [15:0] REPEAT_MARKER = 16'hffff;

   // Phase codes as seen on the result port.
   localparam logic [2:0] PHASE_CODE_HDR1 = 3'd0;
   localparam logic [2:0] PHASE_CODE_HDR2 = 3'd1;
   localparam logic [2:0] PHASE_CODE_STLO = 3'd2;
   localparam logic [2:0] PHASE_CODE_STHI = 3'd3;
   localparam logic [2:0] PHASE_CODE_ENLO = 3'd4;
   localparam logic [2:0] PHASE_CODE_ENHI = 3'd5;
   localparam logic [2:0] PHASE_CODE_DATA = 3'd6;

   typedef enum logic [6:0] {
      PH_HDR1 = 7'b0000001,
      PH_HDR2 = 7'b0000010,
      PH_STLO = 7'b0000100,
      PH_STHI = 7'b0001000,
      PH_ENLO = 7'b0010000,
      PH_ENHI = 7'b0100000,
      PH_DATA = 7'b1000000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] seg_start;
      logic [15:0] seg_finish;
      logic [16:0] next_addr;
   } parse_state_type;

   typedef struct packed {
      logic        write_enable;
      logic [15:0] write_address;
      logic [7:0]  write_value;
      logic        header_error;
      logic        repeated_header;
      logic        segment_end;
      logic [2:0]  phase_after;
   } result_type;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      code = PHASE_CODE_HDR1;
      unique case (ph)
         PH_HDR1: code = PHASE_CODE_HDR1;
         PH_HDR2: code = PHASE_CODE_HDR2;
         PH_STLO: code = PHASE_CODE_STLO;
         PH_STHI: code = PHASE_CODE_STHI;
         PH_ENLO: code = PHASE_CODE_ENLO;
         PH_ENHI: code = PHASE_CODE_ENHI;
         PH_DATA: code = PHASE_CODE_DATA;
         default: code = PHASE_CODE_HDR1;
      endcase
      return code;
   endfunction

endpackage

@@ sv/blsp_step.sv @@
// Next-state and result logic for one stream byte of the parser.
module blsp_step
   import blsp_pkg::*;
(
   input  parse_state_type cur_state,
   input  logic [7:0]      stream_byte,
   output parse_state_type next_state,
   output result_type      result
);

   logic [15:0] start_hi_merged;
   logic [16:0] addr_inc;

   assign start_hi_merged = {stream_byte, cur_state.seg_start[7:0]};
   assign addr_inc        = cur_state.next_addr + 17'd1;

   always_comb begin
      next_state = cur_state;
      result     = '0;
      unique case (cur_state.phase)
         PH_HDR1: begin
            if (stream_byte == HEADER_BYTE) next_state.phase = PH_HDR2;
            else result.header_error = 1'b1;
         end
         PH_HDR2: begin
            if (stream_byte == HEADER_BYTE) next_state.phase = PH_STLO;
            else result.header_error = 1'b1;
         end
         PH_STLO: begin
            next_state.seg_start[7:0] = stream_byte;
            next_state.phase          = PH_STHI;
         end
         PH_STHI: begin
            next_state.seg_start = start_hi_merged;
            if (start_hi_merged == REPEAT_MARKER) begin
               result.repeated_header = 1'b1;
               next_state.phase       = PH_STLO;
            end else begin
               next_state.phase = PH_ENLO;
            end
         end
         PH_ENLO: begin
            next_state.seg_finish[7:0] = stream_byte;
            next_state.phase           = PH_ENHI;
         end
         PH_ENHI: begin
            next_state.seg_finish[15:8] = stream_byte;
            next_state.next_addr        = {1'b0, cur_state.seg_start};
            next_state.phase            = PH_DATA;
         end
         PH_DATA: begin
            result.write_enable  = 1'b1;
            result.write_address = cur_state.next_addr[15:0];
            result.write_value   = stream_byte;
            next_state.next_addr = addr_inc;
            if (addr_inc > {1'b0, cur_state.seg_finish}) begin
               result.segment_end = 1'b1;
               next_state.phase   = PH_STLO;
            end
         end
         default: begin
            next_state.phase = PH_HDR1;
         end
      endcase
      result.phase_after = phase_code(next_state.phase);
   end

endmodule

@@ sv/binary_load_segment_parser.sv @@
// Top level of the binary load segment parser: parser state and result register.
//
// Usage: feed one byte of a binary load stream per req_ beat on req_stream_byte.
// Every accepted byte yields exactly one rsp_ beat. A data byte comes out as a
// memory write (rsp_write_enable, rsp_write_address, rsp_write_value), with
// rsp_segment_end on the last byte of its segment. Header bytes other than
// 0xFF are dropped and flagged on rsp_header_error; a start address of 0xFFFF
// is skipped and flagged on rsp_repeated_header. rsp_phase_after reports the
// parser phase once the byte has been taken.
//
// Timing: the result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while rsp_ready is high; the parser state and one
// compare and 17-bit increment settle combinationally between the parser
// state register and the result register.
// Stall: the result register holds while rsp_ready is low; req_ready stays
// high as long as the register is empty or is being drained this cycle.
// Reset: the parser returns to the first header phase, addresses clear to 0
// and no result is pending.
module binary_load_segment_parser
   import blsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_write_enable,
   output logic [15:0] rsp_write_address,
   output logic [7:0]  rsp_write_value,
   output logic        rsp_header_error,
   output logic        rsp_repeated_header,
   output logic        rsp_segment_end,
   output logic [2:0]  rsp_phase_after
);

   parse_state_type state_ff, state_in;
   result_type      result_ff, result_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_fire;

   // Take a new beat whenever the result slot is free or draining now.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   blsp_step u_step (
      .cur_state  (state_ff),
      .stream_byte(req_stream_byte),
      .next_state (state_in),
      .result     (result_in)
   );

   // Valid flag: set on accept, drop once the receiver takes the beat.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_HDR1;
         state_ff.seg_start  <= '0;
         state_ff.seg_finish <= '0;
         state_ff.next_addr  <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         // Advance the parser only on an accepted beat.
         if (req_fire) state_ff <= state_in;
      end
   end

   // Payload: hold while stalled, load on accept.
   always_ff @(posedge clock) begin
      if (req_fire) result_ff <= result_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_write_enable    = result_ff.write_enable;
   assign rsp_write_address   = result_ff.write_address;
   assign rsp_write_value     = result_ff.write_value;
   assign rsp_header_error    = result_ff.header_error;
   assign rsp_repeated_header = result_ff.repeated_header;
   assign rsp_segment_end     = result_ff.segment_end;
   assign rsp_phase_after     = result_ff.phase_after;

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.phase))
      else $error("parser phase is not one-hot");

   a_phase_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (result_ff.phase_after == phase_code(state_ff.phase)))
      else $error("reported phase disagrees with parser state");

   a_end_needs_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.segment_end |->
         result_ff.write_enable && (result_ff.phase_after == PHASE_CODE_STLO))
      else $error("segment end without a data write");

   a_header_err_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.header_error |->
         (result_ff.phase_after == PHASE_CODE_HDR1) ||
         (result_ff.phase_after == PHASE_CODE_HDR2))
      else $error("header error outside header phases");

   a_repeat_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.repeated_header |->
         (result_ff.phase_after == PHASE_CODE_STLO) && (state_ff.seg_start == REPEAT_MARKER))
      else $error("repeated header flag without 0xFFFF start");

endmodule

@@ tb/binary_load_segment_parser_test.sv @@
// Self-checking testbench for the binary load segment parser: stream bytes in, parse results out.
module binary_load_segment_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import blsp_pkg::*;

   localparam int ITEM_TARGET  = 1550;       // bytes to stream in total
   localparam int TAIL_ITEMS   = 150;        // last bytes run with no idling at all
   localparam int DRAIN_CYCLES = 8;          // results are registered; allow slack
   localparam int MAX_IDLE     = 12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_write_enable;
   logic [15:0] rsp_write_address;
   logic [7:0]  rsp_write_value;
   logic        rsp_header_error;
   logic        rsp_repeated_header;
   logic        rsp_segment_end;
   logic [2:0]  rsp_phase_after;

   // Bytes still to be sent; the front one is on the request port while valid is high.
   logic [7:0]  stream_bytes [$];
   // Parse results predicted for accepted bytes, oldest first.
   result_type  expected_parse [$];

   // Parser state as predicted by the testbench.
   logic [2:0]  model_phase  = PHASE_CODE_HDR1;
   logic [15:0] model_start  = 16'h0000;
   logic [15:0] model_finish = 16'h0000;
   logic [16:0] model_next   = 17'h00000;

   logic        req_took = 1'b0;   // a request beat happened at the last rising edge
   int          req_gap  = 0;
   int          rsp_gap  = 0;
   int          req_pct  = 20;
   int          rsp_pct  = 20;

   int unsigned mismatch_count = 0;
   int unsigned bytes_fed      = 0;
   int unsigned results_seen   = 0;
   int unsigned writes_seen    = 0;
   int unsigned segments_seen  = 0;
   int unsigned repeats_seen   = 0;
   int unsigned hdr_errors     = 0;

   binary_load_segment_parser dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_stream_byte     (req_stream_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_write_enable    (rsp_write_enable),
      .rsp_write_address   (rsp_write_address),
      .rsp_write_value     (rsp_write_value),
      .rsp_header_error    (rsp_header_error),
      .rsp_repeated_header (rsp_repeated_header),
      .rsp_segment_end     (rsp_segment_end),
      .rsp_phase_after     (rsp_phase_after)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Advance the predicted parser by one byte and return the result it should report.
   function automatic result_type parse_byte(input logic [7:0] b);
      result_type r;
      r = '0;
      case (model_phase)
         PHASE_CODE_HDR1: begin
            if (b == HEADER_BYTE) model_phase = PHASE_CODE_HDR2;
            else r.header_error = 1'b1;
         end
         PHASE_CODE_HDR2: begin
            if (b == HEADER_BYTE) model_phase = PHASE_CODE_STLO;
            else r.header_error = 1'b1;
         end
         PHASE_CODE_STLO: begin
            model_start[7:0] = b;
            model_phase = PHASE_CODE_STHI;
         end
         PHASE_CODE_STHI: begin
            model_start[15:8] = b;
            // A start of all ones is a header repeated mid-stream: skip it.
            if (model_start == REPEAT_MARKER) begin
               r.repeated_header = 1'b1;
               model_phase = PHASE_CODE_STLO;
            end else begin
               model_phase = PHASE_CODE_ENLO;
            end
         end
         PHASE_CODE_ENLO: begin
            model_finish[7:0] = b;
            model_phase = PHASE_CODE_ENHI;
         end
         PHASE_CODE_ENHI: begin
            model_finish[15:8] = b;
            model_next = {1'b0, model_start};
            model_phase = PHASE_CODE_DATA;
         end
         PHASE_CODE_DATA: begin
            r.write_enable  = 1'b1;
            r.write_address = model_next[15:0];
            r.write_value   = b;
            // 17-bit address so a write at the top of memory still ends the segment.
            model_next = model_next + 17'd1;
            if (model_next > {1'b0, model_finish}) begin
               r.segment_end = 1'b1;
               model_phase = PHASE_CODE_STLO;
            end
         end
         default: model_phase = PHASE_CODE_HDR1;
      endcase
      r.phase_after = model_phase;
      return r;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Queue one segment: mostly well-formed with random content, some repeated
   // headers, some near the top of memory and some with the end below the start.
   task automatic add_segment();
      int pick;
      int seg_lo;
      int seg_hi;
      int count;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         stream_bytes.push_back(HEADER_BYTE);
         stream_bytes.push_back(HEADER_BYTE);
         return;
      end
      seg_lo = $urandom_range(0, 16'hfffe);
      if (pick < 16) seg_lo = 16'hffff - $urandom_range(1, 24);
      if (pick >= 16 && pick < 26) begin
         if (seg_lo == 0) seg_lo = 1;
         seg_hi = $urandom_range(0, seg_lo - 1);
         count  = 1;
      end else begin
         if ($urandom_range(0, 9) == 0) count = $urandom_range(17, 64);
         else count = $urandom_range(1, 16);
         seg_hi = seg_lo + count - 1;
         if (seg_hi > 16'hffff) seg_hi = 16'hffff;
         count = seg_hi - seg_lo + 1;
      end
      stream_bytes.push_back(seg_lo[7:0]);
      stream_bytes.push_back(seg_lo[15:8]);
      stream_bytes.push_back(seg_hi[7:0]);
      stream_bytes.push_back(seg_hi[15:8]);
      repeat (count) stream_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // Monitor: predict on every request beat, then check every response beat.
   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            expected_parse.push_back(parse_byte(req_stream_byte));
            bytes_fed++;
         end
         if (rsp_valid && rsp_ready) begin
            got.write_enable    = rsp_write_enable;
            got.write_address   = rsp_write_address;
            got.write_value     = rsp_write_value;
            got.header_error    = rsp_header_error;
            got.repeated_header = rsp_repeated_header;
            got.segment_end     = rsp_segment_end;
            got.phase_after     = rsp_phase_after;
            results_seen++;
            if (expected_parse.size() == 0) begin
               $error("result beat with no byte outstanding (phase_after 0x%0h)",
                      rsp_phase_after);
               mismatch_count++;
            end else begin
               want = expected_parse.pop_front();
               check_field("write_enable",    want.write_enable,    got.write_enable);
               check_field("write_address",   want.write_address,   got.write_address);
               check_field("write_value",     want.write_value,     got.write_value);
               check_field("header_error",    want.header_error,    got.header_error);
               check_field("repeated_header", want.repeated_header, got.repeated_header);
               check_field("segment_end",     want.segment_end,     got.segment_end);
               check_field("phase_after",     want.phase_after,     got.phase_after);
               writes_seen   += want.write_enable;
               segments_seen += want.segment_end;
               repeats_seen  += want.repeated_header;
               hdr_errors    += want.header_error;
            end
         end
      end
   end

   // Driver: drop the front byte once its beat is taken, then hold, idle or present the next.
   always @(negedge clock) begin : drive_req
      logic       nxt_valid;
      logic [7:0] nxt_byte;
      nxt_valid = 1'b0;
      nxt_byte  = req_stream_byte;
      if (!reset) begin
         if (req_took) begin
            void'(stream_bytes.pop_front());
            // Now and then switch between quiet and busy stretches.
            if ($urandom_range(0, 99) == 0) req_pct = $urandom_range(0, 3) * 15;
         end
         if (req_valid && !req_took) begin
            nxt_valid = 1'b1;
         end else if (req_gap > 0) begin
            req_gap--;
         end else if (stream_bytes.size() == 0) begin
            nxt_valid = 1'b0;
         end else if (stream_bytes.size() > TAIL_ITEMS && $urandom_range(0, 99) < req_pct) begin
            req_gap = $urandom_range(1, MAX_IDLE) - 1;
         end else begin
            nxt_valid = 1'b1;
            nxt_byte  = stream_bytes[0];
         end
      end
      req_valid       <= nxt_valid;
      req_stream_byte <= nxt_byte;
   end

   // Stall the result side in bursts; release it for the tail of the run.
   always @(negedge clock) begin : drive_rsp
      logic nxt_ready;
      nxt_ready = 1'b1;
      if (!reset) begin
         if ($urandom_range(0, 199) == 0) rsp_pct = $urandom_range(0, 3) * 15;
         if (rsp_gap > 0) begin
            rsp_gap--;
            nxt_ready = 1'b0;
         end else if (stream_bytes.size() > TAIL_ITEMS && $urandom_range(0, 99) < rsp_pct) begin
            rsp_gap   = $urandom_range(1, MAX_IDLE) - 1;
            nxt_ready = 1'b0;
         end
      end
      rsp_ready <= nxt_ready;
   end

   initial begin : run
      logic [7:0] opening [];
      opening = '{
         8'h00,                                // bad first header byte
         8'hff, 8'h7f,                         // first header good, second bad
         8'hff,                                // header complete
         8'hff, 8'hff,                         // start of all ones: repeated header
         8'hfe, 8'hff,                         // start 0xfffe
         8'hff, 8'hff,                         // end 0xffff
         8'h00, 8'hff,                         // data runs up to the top of memory
         8'h10, 8'h00, 8'h05, 8'h00, 8'ha5,    // end below start: one byte, segment done
         8'h34, 8'h12, 8'h34, 8'h12, 8'h5a     // start equals end
      };
      foreach (opening[i]) stream_bytes.push_back(opening[i]);
      while (stream_bytes.size() < ITEM_TARGET) add_segment();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stream_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_parse.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_parse.size() != 0) begin
         $error("%0d results never arrived", expected_parse.size());
         mismatch_count++;
      end
      $display("Streamed %0d bytes and checked %0d results: %0d memory writes in %0d segments,",
               bytes_fed, results_seen, writes_seen, segments_seen);
      $display("%0d repeated headers skipped and %0d bad header bytes dropped.",
               repeats_seen, hdr_errors);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop far beyond the slowest legal run.
   initial begin : watchdog
      #2000000;
      $display("Timeout: %0d bytes still queued, %0d results outstanding",
               stream_bytes.size(), expected_parse.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
